### hdl/sha256_stream_hasher_defines.svh
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

### hdl/sha_pkg.sv
// Package with SHA-256 constants, functions and controller/datapath command types.
package sha_pkg;
   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos = 6'd56;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_WRITE = 3'd1,  // store byte at fill position
      OP_PAD   = 3'd2,  // store pad byte or zero or length byte
      OP_LOAD  = 3'd3,  // load working registers, start round 0
      OP_ROUND = 3'd4,  // one compression round
      OP_FOLD  = 3'd5,  // add working registers into chaining words
      OP_INIT  = 3'd6   // restart for the next message
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] pad_value;
      logic [5:0] addr;
      logic [5:0] round;
      logic       add_bits;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic [7:0] len_byte0;
   } status_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction
endpackage

### hdl/sha_datapath.sv
// SHA-256 datapath: block buffer, schedule window, round logic and chaining words.
module sha_datapath
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [7:0]  data_byte,
   input  logic [2:0]  word_sel,
   output logic [31:0] digest_word,
   output status_type  status
);
   logic [31:0] buf_mem [16];
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] r_ff [8];
   logic [31:0] r_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] w_cur, s0, s1, t1, t2, w_new, blk_ff;
   logic [7:0]  wr_byte;
   logic [3:0]  rd_idx;

   // Bytes of message length, most significant first at the buffer tail.
   assign status.fill = fill_ff;
   assign status.len_byte0 = bits_ff[63:56];
   assign wr_byte = (cmd.op == OP_WRITE) ? data_byte : cmd.pad_value;

   // The buffer holds big-endian block words; byte 0 of a word is its top byte.
   // Block words are fetched one round ahead, so the load cycle fetches word 0.
   assign rd_idx = (cmd.op == OP_ROUND) ? cmd.round[3:0] + 4'd1 : 4'd0;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE || cmd.op == OP_PAD) begin
         buf_mem[cmd.addr[5:2]][{~cmd.addr[1:0], 3'b000} +: 8] <= wr_byte;
      end
      blk_ff <= buf_mem[rd_idx];
   end

   assign s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign w_new = w_ff[0] + s0 + w_ff[9] + s1;
   assign w_cur = cmd.round[5:4] == 2'd0 ? blk_ff : w_new;
   assign t1 = r_ff[7] + (rotr(r_ff[4], 6) ^ rotr(r_ff[4], 11) ^ rotr(r_ff[4], 25))
             + ((r_ff[4] & r_ff[5]) ^ (~r_ff[4] & r_ff[6])) + RoundK[cmd.round] + w_cur;
   assign t2 = (rotr(r_ff[0], 2) ^ rotr(r_ff[0], 13) ^ rotr(r_ff[0], 22))
             + ((r_ff[0] & r_ff[1]) ^ (r_ff[0] & r_ff[2]) ^ (r_ff[1] & r_ff[2]));
   assign digest_word = h_ff[word_sel];

   always_comb begin
      h_in = h_ff;
      r_in = r_ff;
      w_in = w_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      case (cmd.op)
         OP_WRITE: begin
            fill_in = fill_ff + 6'd1;
            bits_in = bits_ff + 64'd8;
         end
         OP_PAD: begin
            // Length bytes shift out of the count one by one, top byte first.
            if (cmd.add_bits) bits_in = {bits_ff[55:0], 8'h00};
         end
         OP_LOAD: r_in = h_ff;
         OP_ROUND: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = w_cur;
            r_in[7] = r_ff[6];
            r_in[6] = r_ff[5];
            r_in[5] = r_ff[4];
            r_in[4] = r_ff[3] + t1;
            r_in[3] = r_ff[2];
            r_in[2] = r_ff[1];
            r_in[1] = r_ff[0];
            r_in[0] = t1 + t2;
         end
         OP_FOLD: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + r_ff[i];
            fill_in = 6'd0;
         end
         OP_INIT: begin
            h_in = InitHash;
            fill_in = 6'd0;
            bits_in = 64'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= InitHash;
         fill_ff <= 6'd0;
         bits_ff <= 64'd0;
      end else begin
         h_ff <= h_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
      end
      r_ff <= r_in;
      w_ff <= w_in;
   end
endmodule

### hdl/sha_controller.sv
// SHA-256 controller: accepts beats, sequences padding, rounds and digest output.
module sha_controller
   import sha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       byte_valid,
   input  logic       end_of_message,
   input  status_type status,
   output cmd_type    cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] word_sel
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PAD   = 6'b000010,
      S_LOAD  = 6'b000100,
      S_ROUND = 6'b001000,
      S_FOLD  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;     // pad position or round number
   logic       last_ff, last_in;   // padding in progress for a closing beat
   logic       len_ff, len_in;     // this pad block carries the length
   logic       pad1_ff, pad1_in;   // pad byte still to be placed
   logic [2:0] word_ff, word_in;
   logic       acc;

   assign req_ready = state_ff == S_IDLE;
   assign acc = req_valid && req_ready;
   assign rsp_valid = state_ff == S_OUT;
   assign word_sel = word_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      last_in = last_ff;
      len_in = len_ff;
      pad1_in = pad1_ff;
      word_in = word_ff;
      cmd = '0;
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (byte_valid) begin
                  cmd.op = OP_WRITE;
                  cmd.addr = status.fill;
               end
               last_in = end_of_message;
               pad1_in = 1'b1;
               cnt_in = byte_valid ? status.fill + 6'd1 : status.fill;
               if (byte_valid && status.fill == 6'd63) begin
                  cnt_in = 6'd0;
                  state_in = S_LOAD;
               end else if (end_of_message) begin
                  state_in = S_PAD;
               end
               // Length fits only when the pad byte lands before the length field.
               len_in = (byte_valid ? status.fill + 6'd1 : status.fill) < LenPos
                        && !(byte_valid && status.fill == 6'd63);
            end
         end
         S_PAD: begin
            cmd.op = OP_PAD;
            cmd.addr = cnt_ff;
            cmd.pad_value = 8'h00;
            if (pad1_ff) cmd.pad_value = PadByte;
            else if (len_ff && cnt_ff >= LenPos) begin
               cmd.pad_value = status.len_byte0;
               cmd.add_bits = 1'b1;
            end
            pad1_in = 1'b0;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.op = OP_LOAD;
            cnt_in = 6'd0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op = OP_ROUND;
            cmd.round = cnt_ff;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.op = OP_FOLD;
            cnt_in = 6'd0;
            if (!last_ff) state_in = S_IDLE;
            else if (len_ff) begin
               word_in = 3'd0;
               state_in = S_OUT;
            end else begin
               // Second block: zeros then length; pad byte already placed
               // unless the block filled exactly with message bytes.
               len_in = 1'b1;
               state_in = S_PAD;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  cmd.op = OP_INIT;
                  last_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= 6'd0;
         last_ff <= 1'b0;
         len_ff <= 1'b0;
         pad1_ff <= 1'b0;
         word_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         last_ff <= last_in;
         len_ff <= len_in;
         pad1_ff <= pad1_in;
         word_ff <= word_in;
      end
   end
endmodule

### hdl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher.
// Usage: one message byte per req beat (req_data_byte, req_byte_valid),
// with req_end_of_message high on the last beat; an empty closing beat
// (byte_valid low) is allowed and gives the empty-message digest.
// The 64th byte of a block starts a compression (load, 64 rounds set by
// the single round unit, fold) during which req_ready is low. A closing
// beat pads the block byte by byte up to position 63, compresses, and
// pads and compresses a second block when the length field does not fit.
// The digest leaves as eight rsp beats, word 0 first, with rsp_final_word
// on word 7; a stalled rsp_ready holds the current word and the block
// accepts nothing until the last word is taken.
// Reset (synchronous, active high) restores the initial hash values and
// clears the fill and length counts; no clearing pass is needed.
module sha256_stream_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_final_word
);
   `include "sha256_stream_hasher_defines.svh"

   cmd_type    cmd;
   status_type status;
   logic [2:0] word_sel;

   sha_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .byte_valid(req_byte_valid), .end_of_message(req_end_of_message),
      .status(status), .cmd(cmd), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .word_sel(word_sel)
   );

   sha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_byte(req_data_byte),
      .word_sel(word_sel), .digest_word(rsp_digest_word), .status(status)
   );

   assign rsp_word_number = word_sel;
   assign rsp_final_word = word_sel == 3'd7;

   `SHA_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `SHA_ASSERT_NEXT(a_word_advance, clock, reset,
                    rsp_valid && rsp_ready && !rsp_final_word,
                    rsp_valid && rsp_word_number == $past(rsp_word_number) + 3'd1)
   `SHA_ASSERT_NEXT(a_final_idle, clock, reset,
                    rsp_valid && rsp_ready && rsp_final_word, req_ready)
endmodule

### sim/tb_sha256_stream_hasher.sv
// Self-checking testbench for the SHA-256 stream hasher, with a built-in digest predictor.
module tb_sha256_stream_hasher;
   timeunit 1ns;
   timeprecision 1ps;
   import sha_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int RandomItems   = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_number;
   logic        rsp_final_word;

   sha256_stream_hasher dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   typedef struct {
      logic [7:0]  data;
      logic        bvalid;
      logic        eom;
      logic        known;
      logic [31:0] word0;
   } stim_row_type;

   const logic [31:0] round_const [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   const logic [31:0] start_hash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   logic [31:0]     hash_words [8];
   logic [7:0]      block_buf [64];
   logic [5:0]      fill;
   logic [63:0]     length_bits;
   digest_word_type pending_digest [$];

   int errors = 0;
   int messages = 0;
   int items_sent = 0;
   int words_seen = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   function automatic logic [31:0] ror32(logic [31:0] v, int n);
      return 32'({v, v} >> n);
   endfunction

   function automatic void compress();
      logic [31:0] w [64];
      logic [31:0] r [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      r = hash_words;
      for (int i = 0; i < 64; i++) begin
         t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
            + ((r[4] & r[5]) ^ (~r[4] & r[6])) + round_const[i] + w[i];
         t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
            + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
         r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         hash_words[i] += r[i];
   endfunction

   function automatic void restart_message();
      hash_words = start_hash;
      fill = '0;
      length_bits = '0;
   endfunction

   // Advances the digest state by one accepted beat and queues any digest words.
   function automatic void absorb_beat(logic [7:0] data, logic bvalid, logic eom,
                                       logic known, logic [31:0] word0);
      int pos;
      digest_word_type dw;
      if (bvalid) begin
         block_buf[fill] = data;
         length_bits += 64'd8;
         fill++;
         if (fill == 0) compress();
      end
      if (!eom) return;
      pos = fill;
      block_buf[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
         while (pos < 64) block_buf[pos++] = 8'h00;
         compress();
         pos = 0;
      end
      while (pos < 56) block_buf[pos++] = 8'h00;
      for (int i = 0; i < 8; i++)
         block_buf[56+i] = length_bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         dw.word = (i == 0 && known) ? word0 : hash_words[i];
         dw.index = i[2:0];
         dw.last = (i == 7);
         pending_digest.push_back(dw);
      end
      messages++;
      restart_message();
   endfunction

   function automatic int gap_length();
      if (quiet) return 0;
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_beat(logic [7:0] data, logic bvalid, logic eom,
                            logic known = 1'b0, logic [31:0] word0 = '0);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_byte_valid <= bvalid;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      absorb_beat(data, bvalid, eom, known, word0);
      items_sent++;
   endtask

   // Receiver: checks each digest beat and stalls at random.
   always @(posedge clock) begin
      digest_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (pending_digest.size() == 0) begin
            $display("%0t: unexpected digest beat, actual word %h index %0d", $time,
                     rsp_digest_word, rsp_word_number);
            errors++;
         end else begin
            exp_w = pending_digest.pop_front();
            if (rsp_digest_word !== exp_w.word || rsp_word_number !== exp_w.index ||
                rsp_final_word !== exp_w.last) begin
               $display("%0t: expected word %h index %0d last %b, actual %h %0d %b",
                        $time, exp_w.word, exp_w.index, exp_w.last,
                        rsp_digest_word, rsp_word_number, rsp_final_word);
               errors++;
            end
         end
      end
      if (quiet) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) rsp_ready <= 1'b0;
      else if (!rsp_ready && $urandom_range(0, 9) < 4) rsp_ready <= 1'b1;
      else if (rsp_ready && $urandom_range(0, 9) < 2) rsp_ready <= 1'b0;
   end

   // Watchdog: a run that stops moving ends as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (!req_valid && pending_digest.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: watchdog expired with %0d digest words outstanding", $time,
                  pending_digest.size());
         $display("Mismatches found");
         $finish;
      end
   end

   stim_row_type directed [14] = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},         // idle beat, no effect
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},  // empty message
      '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},  // "abc"
      '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'h55, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'haa, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 32'h0}          // empty closing beat after bytes
   };

   initial begin
      int len;
      restart_message();
      for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_beat(directed[i].data, directed[i].bvalid, directed[i].eom,
                   directed[i].known, directed[i].word0);

      // Hold the sender until every digest so far has been drained.
      req_valid <= 1'b0;
      while (pending_digest.size() != 0) @(posedge clock);

      // Random messages; lengths near the padding boundaries are favoured, and the
      // 64-bit length wrap is out of reach in simulation.
      while (items_sent < RandomItems) begin
         quiet = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 4))
            0: len = $urandom_range(54, 57);
            1: len = $urandom_range(62, 65);
            2: len = $urandom_range(118, 130);
            default: len = $urandom_range(0, 20);
         endcase
         if (len > RandomItems - items_sent) len = RandomItems - items_sent;
         for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 15) == 0) send_beat(8'($urandom()), 1'b0, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end
         if ($urandom_range(0, 3) == 0) send_beat(8'($urandom()), 1'b0, 1'b1);
         else send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (pending_digest.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Hashed %0d messages from %0d beats, %0d digest words checked,",
               messages, items_sent, words_seen);
      $display("including empty, padding-boundary and multi-block messages.");
      if (errors == 0 && pending_digest.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

### sim.f
+incdir+hdl
hdl/sha_pkg.sv
hdl/sha_datapath.sv
hdl/sha_controller.sv
hdl/sha256_stream_hasher.sv
sim/tb_sha256_stream_hasher.sv
